### src/lmv_pkg.sv
// ----------------------------------------------------------------------------
// lmv_pkg
// shared constants, types and state codes for the 7x7 mean/variance filter
// ----------------------------------------------------------------------------
package lmv_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int WIN         = 7;
    localparam int HALF        = WIN / 2;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS   = $clog2(WIN);
    localparam int MEM_DEPTH   = WIN * MAX_WIDTH;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
    localparam int CNT_BITS    = $clog2(WIN * WIN + 1);
    localparam int ACC_BITS    = 22;
    localparam int DIM_BITS    = 9;

    // command queue between front and back, and result queue
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH    = 2;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0]          pixel;
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
        logic [SLOT_BITS-1:0] slot;
        logic                wr;
        logic                prod;
        logic [7:0]          cc;
        logic [7:0]          cr;
        logic                fend;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  mean;
        logic [13:0] var_q;
        logic [7:0]  cc;
        logic [7:0]  cr;
        logic        fend;
    } t_res;

    // front to back command channel
    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_cmd_chan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_PASS,
        S_DRAIN,
        S_DIVM,
        S_DIVV,
        S_OUT
    } t_state;

endpackage

### src/lmv_front.sv
// ----------------------------------------------------------------------------
// lmv_front
// scan position tracking, frame registers and the command queue
// ----------------------------------------------------------------------------
module lmv_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_pixel,
    input  logic                        i_cfg_valid,
    input  logic [1:0]                  i_cfg_index,
    input  logic [lmv_pkg::DIM_BITS-1:0] i_cfg_data,
    output lmv_pkg::t_cmd_chan          o_chan,
    input  logic                        i_cmd_pop
);
    logic [lmv_pkg::DIM_BITS-1:0] r_fw, r_fh, r_col, r_row;
    logic [lmv_pkg::SLOT_BITS-1:0] r_slot;
    lmv_pkg::t_cmd r_q [lmv_pkg::CMD_DEPTH];
    logic [lmv_pkg::CMD_PTR_BITS-1:0] r_wp, r_rp;
    logic [lmv_pkg::CMD_PTR_BITS:0] r_cnt;

    logic [lmv_pkg::DIM_BITS-1:0] w, h;
    logic [9:0] col1, row1, wlim, hlim;
    logic acc, pop_ok;
    lmv_pkg::t_cmd cmd;

    always_comb begin
        w = (r_fw == '0) ? 9'd1 : ((r_fw > 9'(lmv_pkg::MAX_WIDTH)) ?
            9'(lmv_pkg::MAX_WIDTH) : r_fw);
        h = (r_fh == '0) ? 9'd1 : ((r_fh > 9'(lmv_pkg::MAX_HEIGHT)) ?
            9'(lmv_pkg::MAX_HEIGHT) : r_fh);
        wlim = {1'b0, w} + 10'(lmv_pkg::HALF);
        hlim = {1'b0, h} + 10'(lmv_pkg::HALF);
        col1 = {1'b0, r_col} + 10'd1;
        row1 = {1'b0, r_row} + 10'd1;
        cmd.pixel = i_pixel;
        cmd.col   = r_col;
        cmd.row   = r_row;
        cmd.slot  = r_slot;
        cmd.wr    = (r_row < h) && (r_col < w);
        cmd.prod  = (r_row >= 9'(lmv_pkg::HALF)) && (r_col >= 9'(lmv_pkg::HALF));
        cmd.cc    = 8'(r_col - 9'(lmv_pkg::HALF));
        cmd.cr    = 8'(r_row - 9'(lmv_pkg::HALF));
        cmd.fend  = ({1'b0, r_row} + 10'd1 == hlim) && (col1 == wlim);
        cmd.w     = w;
        cmd.h     = h;
    end

    assign full   = (r_cnt == (lmv_pkg::CMD_PTR_BITS + 1)'(lmv_pkg::CMD_DEPTH));
    assign acc    = push && !full;
    assign pop_ok = i_cmd_pop && (r_cnt != '0);
    assign o_chan.vld = (r_cnt != '0);
    assign o_chan.cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= 9'(lmv_pkg::MAX_WIDTH);
            r_fh   <= 9'(lmv_pkg::MAX_HEIGHT);
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == lmv_pkg::REG_FRAME_WIDTH) begin
                    r_fw <= i_cfg_data;
                end
                if (i_cfg_index == lmv_pkg::REG_FRAME_HEIGHT) begin
                    r_fh <= i_cfg_data;
                end
                if (i_cfg_index == lmv_pkg::REG_FRAME_WIDTH ||
                    i_cfg_index == lmv_pkg::REG_FRAME_HEIGHT) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_slot <= '0;
                end
            end else if (acc) begin
                if (col1 >= wlim) begin
                    r_col <= '0;
                    if (row1 >= hlim) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= row1[8:0];
                        r_slot <= (r_slot == 3'(lmv_pkg::WIN - 1)) ? '0 : r_slot + 3'd1;
                    end
                end else begin
                    r_col <= col1[8:0];
                end
            end
            if (acc) begin
                r_wp <= r_wp + lmv_pkg::CMD_PTR_BITS'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + lmv_pkg::CMD_PTR_BITS'(1);
            end
            r_cnt <= r_cnt + (lmv_pkg::CMD_PTR_BITS + 1)'(acc)
                           - (lmv_pkg::CMD_PTR_BITS + 1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

### src/lmv_div.sv
// ----------------------------------------------------------------------------
// lmv_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lmv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lmv_pkg::ACC_BITS-1:0]  i_num,
    input  logic [lmv_pkg::CNT_BITS-1:0]  i_den,
    output logic                          o_done,
    output logic [lmv_pkg::ACC_BITS-1:0]  o_quo
);
    logic [lmv_pkg::ACC_BITS-1:0] r_quo;
    logic [lmv_pkg::CNT_BITS-1:0] r_den, r_rem;
    logic [4:0] r_left;
    logic r_busy, r_done;
    logic [lmv_pkg::CNT_BITS:0] sh, diff;

    always_comb begin
        sh   = {r_rem, r_quo[lmv_pkg::ACC_BITS-1]};
        diff = sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= 5'(lmv_pkg::ACC_BITS - 1);
            end else if (r_busy) begin
                r_left <= r_left - 5'd1;
                if (r_left == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                r_rem <= diff[lmv_pkg::CNT_BITS-1:0];
                r_quo <= {r_quo[lmv_pkg::ACC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= sh[lmv_pkg::CNT_BITS-1:0];
                r_quo <= {r_quo[lmv_pkg::ACC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### src/lmv_back.sv
// ----------------------------------------------------------------------------
// lmv_back
// line memory, window sum and squared deviation passes, result queue
// ----------------------------------------------------------------------------
module lmv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lmv_pkg::t_cmd_chan   i_chan,
    output logic                 o_cmd_pop,
    output logic                 empty,
    input  logic                 pop,
    output lmv_pkg::t_res        o_res
);
    typedef logic [lmv_pkg::ADDR_BITS-1:0] t_addr;

    logic [7:0] r_mem [lmv_pkg::MEM_DEPTH];
    lmv_pkg::t_state r_st, n_st;
    lmv_pkg::t_cmd r_cmd;
    logic [2:0] r_k, r_j;
    logic [lmv_pkg::SLOT_BITS-1:0] r_rslot;
    logic r_pass, r_rd_vld, r_v2_vld;
    logic [7:0] r_q, r_mean;
    logic [15:0] r_v2;
    logic [lmv_pkg::ACC_BITS-1:0] r_acc;
    logic [lmv_pkg::CNT_BITS-1:0] r_cnt;
    logic [13:0] r_var;
    lmv_pkg::t_res r_oq [lmv_pkg::RES_DEPTH];
    logic [lmv_pkg::RES_PTR_BITS-1:0] r_owp, r_orp;
    logic [lmv_pkg::RES_PTR_BITS:0] r_ocnt;

    logic rd_en, wr_en, last, div_start, div_done, opush, opop, ofull;
    logic [9:0] rr, ccol;
    t_addr raddr, waddr;
    logic [lmv_pkg::ACC_BITS-1:0] quo;
    logic [8:0] d;
    logic [7:0] ad;
    lmv_pkg::t_res res;

    lmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        rr    = {1'b0, r_cmd.row} + 10'(r_k);
        ccol  = {1'b0, r_cmd.col} + 10'(r_j);
        rd_en = (r_st == lmv_pkg::S_PASS) &&
                (rr >= 10'(lmv_pkg::WIN - 1)) &&
                (rr - 10'(lmv_pkg::WIN - 1) < {1'b0, r_cmd.h}) &&
                (ccol >= 10'(lmv_pkg::WIN - 1)) &&
                (ccol - 10'(lmv_pkg::WIN - 1) < {1'b0, r_cmd.w});
        raddr = t_addr'(r_rslot) * t_addr'(lmv_pkg::MAX_WIDTH) +
                t_addr'(8'(ccol - 10'(lmv_pkg::WIN - 1)));
        waddr = t_addr'(r_cmd.slot) * t_addr'(lmv_pkg::MAX_WIDTH) +
                t_addr'(r_cmd.col[7:0]);
        wr_en = (r_st == lmv_pkg::S_WRITE) && r_cmd.wr;
        last  = (r_k == 3'(lmv_pkg::WIN - 1)) && (r_j == 3'(lmv_pkg::WIN - 1));
        d     = {1'b0, r_q} - {1'b0, r_mean};
        ad    = d[8] ? 8'(-d) : d[7:0];
        ofull = (r_ocnt == (lmv_pkg::RES_PTR_BITS + 1)'(lmv_pkg::RES_DEPTH));
        opop  = pop && (r_ocnt != '0);
        res.mean  = r_mean;
        res.var_q = r_var;
        res.cc    = r_cmd.cc;
        res.cr    = r_cmd.cr;
        res.fend  = r_cmd.fend;
    end

    // next state
    always_comb begin
        n_st      = r_st;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        opush     = 1'b0;
        case (r_st)
            lmv_pkg::S_IDLE: begin
                if (i_chan.vld) begin
                    o_cmd_pop = 1'b1;
                    n_st = lmv_pkg::S_WRITE;
                end
            end
            lmv_pkg::S_WRITE: begin
                n_st = r_cmd.prod ? lmv_pkg::S_PASS : lmv_pkg::S_IDLE;
            end
            lmv_pkg::S_PASS: begin
                if (last) begin
                    n_st = lmv_pkg::S_DRAIN;
                end
            end
            lmv_pkg::S_DRAIN: begin
                if (!r_rd_vld && !r_v2_vld) begin
                    div_start = 1'b1;
                    n_st = r_pass ? lmv_pkg::S_DIVV : lmv_pkg::S_DIVM;
                end
            end
            lmv_pkg::S_DIVM: begin
                if (div_done) begin
                    n_st = lmv_pkg::S_PASS;
                end
            end
            lmv_pkg::S_DIVV: begin
                if (div_done) begin
                    n_st = lmv_pkg::S_OUT;
                end
            end
            lmv_pkg::S_OUT: begin
                if (!ofull) begin
                    opush = 1'b1;
                    n_st = lmv_pkg::S_IDLE;
                end
            end
            default: n_st = lmv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= lmv_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
            r_v2_vld <= 1'b0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_st     <= n_st;
            r_rd_vld <= rd_en;
            r_v2_vld <= r_rd_vld;
            if (opush) begin
                r_owp <= r_owp + lmv_pkg::RES_PTR_BITS'(1);
            end
            if (opop) begin
                r_orp <= r_orp + lmv_pkg::RES_PTR_BITS'(1);
            end
            r_ocnt <= r_ocnt + (lmv_pkg::RES_PTR_BITS + 1)'(opush)
                             - (lmv_pkg::RES_PTR_BITS + 1)'(opop);
        end
    end

    // line memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= r_cmd.pixel;
        end
        if (rd_en) begin
            r_q <= r_mem[raddr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_chan.cmd;
        end
        if (r_st == lmv_pkg::S_WRITE || (r_st == lmv_pkg::S_DIVM && div_done)) begin
            r_k     <= '0;
            r_j     <= '0;
            r_rslot <= (r_cmd.slot == 3'(lmv_pkg::WIN - 1)) ? '0 : r_cmd.slot + 3'd1;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_pass  <= (r_st == lmv_pkg::S_DIVM);
        end else begin
            if (r_st == lmv_pkg::S_PASS) begin
                if (r_j == 3'(lmv_pkg::WIN - 1)) begin
                    r_j <= '0;
                    r_k <= r_k + 3'd1;
                    r_rslot <= (r_rslot == 3'(lmv_pkg::WIN - 1)) ? '0 : r_rslot + 3'd1;
                end else begin
                    r_j <= r_j + 3'd1;
                end
            end
            if (r_v2_vld) begin
                r_acc <= r_acc + lmv_pkg::ACC_BITS'(r_v2);
                r_cnt <= r_cnt + lmv_pkg::CNT_BITS'(1);
            end
        end
        if (r_rd_vld) begin
            r_v2 <= r_pass ? (16'(ad) * 16'(ad)) : {8'd0, r_q};
        end
        if (r_st == lmv_pkg::S_DIVM && div_done) begin
            r_mean <= quo[7:0];
        end
        if (r_st == lmv_pkg::S_DIVV && div_done) begin
            r_var <= quo[13:0];
        end
        if (opush) begin
            r_oq[r_owp] <= res;
        end
    end

    assign empty = (r_ocnt == '0);
    assign o_res = r_oq[r_orp];

endmodule

### src/local_mean_variance_7x7.sv
// ----------------------------------------------------------------------------
// local_mean_variance_7x7
// truncated mean and variance over a centred 7x7 window of a grey image
// ----------------------------------------------------------------------------
// a result is ready once its item is accepted and has gone through pop, write, two
//   window passes over the 7x7 positions each with a drain, two divisions and out
// items with no result need only pop and write; the back end takes no new item until
//   the last is done, set by the single line memory read port and the serial divider
// a 4-deep command queue takes items in bursts ahead of the window engine
// reset: synchronous active low, scan returns to zero and both queues empty,
//   frame size returns to 256 by 256; line memory contents are not cleared
// ----------------------------------------------------------------------------
module local_mean_variance_7x7 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_pixel,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_local_mean,
    output logic [13:0] o_local_variance,
    output logic [7:0]  o_center_col,
    output logic [7:0]  o_center_row,
    output logic        o_frame_end,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    lmv_pkg::t_cmd_chan chan;
    lmv_pkg::t_res      res;
    logic               cmd_pop;

    // config writes are always taken at once
    assign o_cfg_ready = 1'b1;

    // front: scan position, in-frame/output flags, command queue
    lmv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_chan      (chan),
        .i_cmd_pop   (cmd_pop)
    );

    // back: line memory write, sum pass, variance pass, result queue
    lmv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chan    (chan),
        .o_cmd_pop (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .o_res     (res)
    );

    assign o_local_mean     = res.mean;
    assign o_local_variance = res.var_q;
    assign o_center_col     = res.cc;
    assign o_center_row     = res.cr;
    assign o_frame_end      = res.fend;

    // result queue starts empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // the back end only takes a command that the front holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> chan.vld)
        else $error("command taken from an empty queue");

    // a waiting result is not lost while pop is low
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_local_mean))
        else $error("waiting result changed");

endmodule
